// ===== design/pdmd_pkg.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// pdmd_pkg
// Shared widths, register map, status structs and saturation helpers for the
// PD-driven mass-damper step core.
// -----------------------------------------------------------------------------
package pdmd_pkg;

	// Serial multiplier: signed multiplicand, unsigned multiplier scanned LSB first.
	localparam int MUL_A_W   = 33;
	localparam int MUL_B_W   = 32;
	localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
	localparam int MUL_CNT_W = $clog2(MUL_B_W + 1);

	// Serial divider: 64-bit numerator, 31-bit divisor, quotient bits kept.
	localparam int DIV_N_W   = 64;
	localparam int DIV_D_W   = 31;
	localparam int DIV_STEPS = DIV_N_W - DIV_D_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

	localparam int VAL_W  = 32;
	localparam int COST_W = 63;
	localparam int GAIN_W = 31;
	localparam int TS_W   = 17;

	localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
	localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

	// Register map, one 32-bit word per register.
	localparam int PADDR_W   = 5;
	localparam int REG_IDX_W = PADDR_W - 2;
	localparam logic [REG_IDX_W-1:0] REG_MASS      = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_DAMPING   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_GAIN_P    = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_GAIN_D    = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_TIME_STEP = 3'd4;

	localparam logic [GAIN_W-1:0] MASS_RST    = 31'd65536;
	localparam logic [GAIN_W-1:0] DAMPING_RST = 31'd65536;
	localparam logic [GAIN_W-1:0] GAIN_P_RST  = 31'd65536;
	localparam logic [GAIN_W-1:0] GAIN_D_RST  = 31'd131072;
	localparam logic [TS_W-1:0]   TS_RST      = 17'd655;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

	typedef struct packed {
		logic rd;
		logic wr;
	} store_cmd_t;

	function automatic logic signed [63:0] sat64(input logic signed [64:0] x);
		logic signed [63:0] r;
		if (x[64] != x[63]) begin
			r = x[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
		end else begin
			r = x[63:0];
		end
		return r;
	endfunction

	function automatic logic signed [VAL_W-1:0] sat32(input logic signed [VAL_W+2:0] x);
		logic signed [VAL_W-1:0] r;
		if (x[VAL_W+2:VAL_W-1] == 4'b0000 || x[VAL_W+2:VAL_W-1] == 4'b1111) begin
			r = x[VAL_W-1:0];
		end else begin
			r = x[VAL_W+2] ? VAL_MIN : VAL_MAX;
		end
		return r;
	endfunction

endpackage

// ===== design/pdmd_in_if.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// pdmd_in_if
// Request channel: one reference sample for one dimension.
// -----------------------------------------------------------------------------
interface pdmd_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] ref_pos;
	logic signed [31:0] ref_vel;
	logic signed [31:0] ref_acc;
	logic [2:0]         dim_index;
	logic               restart;
	logic               last_dim;

	modport source (
		output valid, ref_pos, ref_vel, ref_acc, dim_index, restart, last_dim,
		input  ready
	);

	modport sink (
		input  valid, ref_pos, ref_vel, ref_acc, dim_index, restart, last_dim,
		output ready
	);
endinterface

// ===== design/pdmd_out_if.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// pdmd_out_if
// Result channel: new plant state, acceleration and time-step cost.
// -----------------------------------------------------------------------------
interface pdmd_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] pos;
	logic signed [31:0] vel;
	logic signed [31:0] acc;
	logic [2:0]         out_dim;
	logic [62:0]        step_cost;
	logic               cost_valid;

	modport source (
		output valid, pos, vel, acc, out_dim, step_cost, cost_valid,
		input  ready
	);

	modport sink (
		input  valid, pos, vel, acc, out_dim, step_cost, cost_valid,
		output ready
	);
endinterface

// ===== design/pdmd_mul.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// pdmd_mul
// Radix-2 shift-and-add multiplier: one multiplier bit per cycle.
// -----------------------------------------------------------------------------
module pdmd_mul import pdmd_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      go,
	input  logic signed [MUL_A_W-1:0] a,
	input  logic [MUL_B_W-1:0]        b,
	output unit_stat_t                stat,
	output logic signed [MUL_P_W-1:0] prod
);

	logic                      busy_q;
	logic                      done_q;
	logic [MUL_CNT_W-1:0]      cnt_q;
	logic signed [MUL_A_W-1:0] a_q;
	logic signed [MUL_A_W-1:0] hi_q;
	logic [MUL_B_W-1:0]        lo_q;
	logic [MUL_A_W:0]          sum;

	// The upper half accumulates; the lower half holds the remaining multiplier
	// bits and collects the low product bits as they shift out of the adder.
	always_comb begin
		sum = {hi_q[MUL_A_W-1], hi_q};
		if (lo_q[0]) begin
			sum = sum + {a_q[MUL_A_W-1], a_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= MUL_CNT_W'(MUL_B_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - MUL_CNT_W'(1);
				if (cnt_q == MUL_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			a_q  <= a;
			hi_q <= '0;
			lo_q <= b;
		end else if (busy_q) begin
			hi_q <= sum[MUL_A_W:1];
			lo_q <= {sum[0], lo_q[MUL_B_W-1:1]};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign prod      = {hi_q, lo_q};

endmodule

// ===== design/pdmd_div.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// pdmd_div
// Restoring divider, one quotient bit per cycle, truncating toward zero and
// saturating the quotient to 32 bits signed.
// -----------------------------------------------------------------------------
module pdmd_div import pdmd_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      go,
	input  logic signed [DIV_N_W-1:0] num,
	input  logic [DIV_D_W-1:0]        den,
	output unit_stat_t                stat,
	output logic signed [VAL_W-1:0]   quo
);

	logic                    busy_q;
	logic                    done_q;
	logic [DIV_CNT_W-1:0]    cnt_q;
	logic                    neg_q;
	logic [DIV_D_W-1:0]      den_q;
	logic [DIV_D_W-1:0]      rem_q;
	logic [DIV_STEPS-1:0]    dq_q;
	logic signed [VAL_W-1:0] quo_q;

	logic [DIV_N_W-1:0]      mag;
	logic                    early;
	logic signed [VAL_W-1:0] early_val;
	logic [DIV_D_W:0]        trial;
	logic [DIV_D_W:0]        diff;
	logic                    ge;
	logic [DIV_STEPS-1:0]    dq_nxt;
	logic                    q_big;
	logic signed [VAL_W-1:0] final_val;

	always_comb begin
		mag = num[DIV_N_W-1] ? (~num + DIV_N_W'(1)) : num;
		// A quotient of 2^33 or more, or a zero divisor, saturates at once.
		early = (num == '0) || (den == '0) || (mag[DIV_N_W-1 -: DIV_D_W] >= den);
		if (num == '0) begin
			early_val = '0;
		end else if (num[DIV_N_W-1]) begin
			early_val = VAL_MIN;
		end else begin
			early_val = VAL_MAX;
		end

		trial  = {rem_q, dq_q[DIV_STEPS-1]};
		diff   = trial - {1'b0, den_q};
		ge     = (trial >= {1'b0, den_q});
		dq_nxt = {dq_q[DIV_STEPS-2:0], ge};

		// Negative quotients may reach 2^31, positive ones only 2^31 - 1.
		if (neg_q) begin
			q_big     = (dq_nxt[DIV_STEPS-1:VAL_W] != '0) ||
			            (dq_nxt[VAL_W-1] && (dq_nxt[VAL_W-2:0] != '0));
			final_val = q_big ? VAL_MIN : (~dq_nxt[VAL_W-1:0] + VAL_W'(1));
		end else begin
			q_big     = (dq_nxt[DIV_STEPS-1:VAL_W-1] != '0);
			final_val = q_big ? VAL_MAX : dq_nxt[VAL_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				if (early) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= DIV_CNT_W'(DIV_STEPS);
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			neg_q <= num[DIV_N_W-1];
			den_q <= den;
			rem_q <= mag[DIV_N_W-1 -: DIV_D_W];
			dq_q  <= mag[DIV_STEPS-1:0];
			quo_q <= early_val;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
			dq_q  <= dq_nxt;
			if (cnt_q == DIV_CNT_W'(1)) begin
				quo_q <= final_val;
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quo       = quo_q;

endmodule

// ===== design/pdmd_store.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// pdmd_store
// Per-dimension plant position and velocity, with a valid bit per entry so
// that entries not yet written read as zero after reset.
// -----------------------------------------------------------------------------
module pdmd_store import pdmd_pkg::*; #(
	parameter  int DIMS = 8,
	localparam int AW   = (DIMS > 1) ? $clog2(DIMS) : 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  store_cmd_t              cmd,
	input  logic [AW-1:0]           addr,
	input  logic signed [VAL_W-1:0] wr_pos,
	input  logic signed [VAL_W-1:0] wr_vel,
	output logic signed [VAL_W-1:0] rd_pos,
	output logic signed [VAL_W-1:0] rd_vel
);

	logic signed [VAL_W-1:0] pos_mem [DIMS];
	logic signed [VAL_W-1:0] vel_mem [DIMS];
	logic [DIMS-1:0]         valid_q;
	logic                    vld_rd_q;
	logic signed [VAL_W-1:0] pos_rd_q;
	logic signed [VAL_W-1:0] vel_rd_q;

	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			pos_mem[addr] <= wr_pos;
			vel_mem[addr] <= wr_vel;
		end
		if (cmd.rd) begin
			pos_rd_q <= pos_mem[addr];
			vel_rd_q <= vel_mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			vld_rd_q <= 1'b0;
		end else begin
			if (cmd.wr) begin
				valid_q[addr] <= 1'b1;
			end
			if (cmd.rd) begin
				vld_rd_q <= valid_q[addr];
			end
		end
	end

	assign rd_pos = vld_rd_q ? pos_rd_q : '0;
	assign rd_vel = vld_rd_q ? vel_rd_q : '0;

endmodule

// ===== design/pd_driven_mass_damper_step_core.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// pd_driven_mass_damper_step_core
// One Euler step of a PD-driven mass-damper plant per request, Q16.16.
// -----------------------------------------------------------------------------
// Usage:
// A request on req carries a reference position, velocity and acceleration for
// one dimension. The core forms the PD plus feed-forward numerator, divides it
// by the mass, integrates velocity and position and returns one result on rsp
// with the new state, the acceleration and, when last_dim was set, the summed
// squared accelerations of the time step. Both channels use valid/ready.
// Requests are taken one at a time. Each result needs six products on the shared
// bit-serial multiplier and one 33-step restoring division; the divider ends at
// once when the quotient saturates or the mass is zero. The next request can be
// taken in the cycle after the result is loaded; no new request is accepted
// before the last one has finished.
// A finished result sits in an output register; a new request is accepted while
// it waits, and the core holds its next result until rsp is free.
// Reset clears all plant state to zero (per-entry valid bits, no clearing pass),
// zeroes the cost sum, loads the register defaults. The user must write registers
// through the APB port only while no request is in flight; this is unchecked.
// -----------------------------------------------------------------------------
module pd_driven_mass_damper_step_core import pdmd_pkg::*; #(
	parameter int DIMS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	pdmd_in_if.sink            req,
	pdmd_out_if.source         rsp,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int AW = (DIMS > 1) ? $clog2(DIMS) : 1;
	localparam logic [6:0] DIMS_C = 7'(DIMS);

	typedef enum logic [3:0] {
		S_IDLE,
		S_READ,
		S_LOAD,
		S_MASS,
		S_GP,
		S_GD,
		S_DIV,
		S_VSTEP,
		S_PSTEP,
		S_SQ,
		S_DONE
	} state_t;

	state_t state_q;

	logic [GAIN_W-1:0] mass_q;
	logic [GAIN_W-1:0] damping_q;
	logic [GAIN_W-1:0] gain_p_q;
	logic [GAIN_W-1:0] gain_d_q;
	logic [TS_W-1:0]   time_step_q;

	logic signed [VAL_W-1:0] rp_q, rv_q, ra_q;
	logic [2:0]              dim_q;
	logic                    restart_q;
	logic                    last_q;
	logic [AW-1:0]           slot_q;
	logic signed [VAL_W-1:0] p_q, v_q;
	logic signed [63:0]      num_q;
	logic signed [VAL_W-1:0] acc_q, nv_q, np_q;
	logic [COST_W-1:0]       sq_q;
	logic [COST_W-1:0]       cost_q;

	logic                    out_valid_q;
	logic signed [VAL_W-1:0] res_pos_q, res_vel_q, res_acc_q;
	logic [2:0]              res_dim_q;
	logic [COST_W-1:0]       res_cost_q;
	logic                    res_cv_q;

	logic                      mul_go_q;
	logic signed [MUL_A_W-1:0] mul_a_q;
	logic [MUL_B_W-1:0]        mul_b_q;
	unit_stat_t                mul_stat;
	logic signed [MUL_P_W-1:0] mul_prod;
	logic                      div_go_q;
	unit_stat_t                div_stat;
	logic signed [VAL_W-1:0]   div_quo;

	store_cmd_t              st_cmd;
	logic signed [VAL_W-1:0] st_pos, st_vel;

	logic                    cfg_wr;
	logic [REG_IDX_W-1:0]    cfg_idx;
	logic [6:0]              slot_w;
	logic [AW-1:0]           slot_c;
	logic                    out_free;
	logic                    out_load;
	logic signed [32:0]      dp_c, dv_c;
	logic signed [64:0]      num_sum_c;
	logic signed [VAL_W-1:0] base_c;
	logic signed [VAL_W-1:0] euler_c;
	logic signed [32:0]      acc_ext_c;
	logic signed [32:0]      acc_mag_c;
	logic [COST_W:0]         cost_sum_c;
	logic [COST_W-1:0]       cost_new_c;

	// ---------------------------------------------------------------- registers
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = paddr[PADDR_W-1:2];
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mass_q      <= MASS_RST;
			damping_q   <= DAMPING_RST;
			gain_p_q    <= GAIN_P_RST;
			gain_d_q    <= GAIN_D_RST;
			time_step_q <= TS_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_MASS:      mass_q      <= pwdata[GAIN_W-1:0];
				REG_DAMPING:   damping_q   <= pwdata[GAIN_W-1:0];
				REG_GAIN_P:    gain_p_q    <= pwdata[GAIN_W-1:0];
				REG_GAIN_D:    gain_d_q    <= pwdata[GAIN_W-1:0];
				REG_TIME_STEP: time_step_q <= pwdata[TS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_MASS:      prdata = {1'b0, mass_q};
			REG_DAMPING:   prdata = {1'b0, damping_q};
			REG_GAIN_P:    prdata = {1'b0, gain_p_q};
			REG_GAIN_D:    prdata = {1'b0, gain_d_q};
			REG_TIME_STEP: prdata = {15'b0, time_step_q};
			default:       prdata = '0;
		endcase
	end

	// ----------------------------------------------------------------- datapath
	// Dimension indexes beyond the table wrap around modulo DIMS.
	always_comb begin
		slot_w = {4'b0, req.dim_index};
		for (int i = 0; i < 8; i++) begin
			if (slot_w >= DIMS_C) begin
				slot_w = slot_w - DIMS_C;
			end
		end
		slot_c = slot_w[AW-1:0];
	end

	assign dp_c      = {rp_q[VAL_W-1], rp_q} - {p_q[VAL_W-1], p_q};
	assign dv_c      = {rv_q[VAL_W-1], rv_q} - {v_q[VAL_W-1], v_q};
	assign num_sum_c = {num_q[63], num_q} + {mul_prod[63], mul_prod[63:0]};

	// Shared Euler update: the product is floored by 2^16 and added to the
	// old velocity, then to the old position.
	assign base_c  = (state_q == S_VSTEP) ? v_q : p_q;
	assign euler_c = sat32({{3{base_c[VAL_W-1]}}, base_c} + mul_prod[50:16]);

	assign acc_ext_c = {acc_q[VAL_W-1], acc_q};
	assign acc_mag_c = acc_q[VAL_W-1] ? (~acc_ext_c + 33'sd1) : acc_ext_c;

	assign cost_sum_c = {1'b0, cost_q} + {1'b0, sq_q};
	assign cost_new_c = cost_sum_c[COST_W] ? COST_MAX : cost_sum_c[COST_W-1:0];

	assign out_free  = !out_valid_q || rsp.ready;
	assign out_load  = (state_q == S_DONE) && out_free;
	assign req.ready = (state_q == S_IDLE);

	assign st_cmd.rd = (state_q == S_READ);
	assign st_cmd.wr = out_load;

	// ------------------------------------------------------------------ control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rp_q        <= '0;
			rv_q        <= '0;
			ra_q        <= '0;
			dim_q       <= '0;
			restart_q   <= 1'b0;
			last_q      <= 1'b0;
			slot_q      <= '0;
			p_q         <= '0;
			v_q         <= '0;
			num_q       <= '0;
			acc_q       <= '0;
			nv_q        <= '0;
			np_q        <= '0;
			sq_q        <= '0;
			cost_q      <= '0;
			out_valid_q <= 1'b0;
			res_pos_q   <= '0;
			res_vel_q   <= '0;
			res_acc_q   <= '0;
			res_dim_q   <= '0;
			res_cost_q  <= '0;
			res_cv_q    <= 1'b0;
			mul_go_q    <= 1'b0;
			mul_a_q     <= '0;
			mul_b_q     <= '0;
			div_go_q    <= 1'b0;
		end else begin
			mul_go_q <= 1'b0;
			div_go_q <= 1'b0;
			if (out_valid_q && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						rp_q      <= req.ref_pos;
						rv_q      <= req.ref_vel;
						ra_q      <= req.ref_acc;
						dim_q     <= req.dim_index;
						restart_q <= req.restart;
						last_q    <= req.last_dim;
						slot_q    <= slot_c;
						state_q   <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					p_q      <= restart_q ? '0 : st_pos;
					v_q      <= restart_q ? '0 : st_vel;
					mul_a_q  <= {ra_q[VAL_W-1], ra_q};
					mul_b_q  <= {1'b0, mass_q};
					mul_go_q <= 1'b1;
					state_q  <= S_MASS;
				end
				S_MASS: begin
					if (mul_stat.done) begin
						num_q    <= mul_prod[63:0];
						mul_a_q  <= dp_c;
						mul_b_q  <= {1'b0, gain_p_q};
						mul_go_q <= 1'b1;
						state_q  <= S_GP;
					end
				end
				S_GP: begin
					if (mul_stat.done) begin
						num_q    <= sat64(num_sum_c);
						mul_a_q  <= dv_c;
						mul_b_q  <= {1'b0, gain_d_q};
						mul_go_q <= 1'b1;
						state_q  <= S_GD;
					end
				end
				S_GD: begin
					if (mul_stat.done) begin
						num_q    <= sat64(num_sum_c);
						div_go_q <= 1'b1;
						state_q  <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_stat.done) begin
						acc_q    <= div_quo;
						mul_a_q  <= {div_quo[VAL_W-1], div_quo};
						mul_b_q  <= {15'b0, time_step_q};
						mul_go_q <= 1'b1;
						state_q  <= S_VSTEP;
					end
				end
				S_VSTEP: begin
					if (mul_stat.done) begin
						// The position step uses the new velocity.
						nv_q     <= euler_c;
						mul_a_q  <= {euler_c[VAL_W-1], euler_c};
						mul_b_q  <= {15'b0, time_step_q};
						mul_go_q <= 1'b1;
						state_q  <= S_PSTEP;
					end
				end
				S_PSTEP: begin
					if (mul_stat.done) begin
						np_q     <= euler_c;
						mul_a_q  <= acc_mag_c;
						mul_b_q  <= acc_mag_c[MUL_B_W-1:0];
						mul_go_q <= 1'b1;
						state_q  <= S_SQ;
					end
				end
				S_SQ: begin
					if (mul_stat.done) begin
						sq_q    <= mul_prod[COST_W-1:0];
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						res_pos_q   <= np_q;
						res_vel_q   <= nv_q;
						res_acc_q   <= acc_q;
						res_dim_q   <= dim_q;
						res_cv_q    <= last_q;
						if (last_q) begin
							res_cost_q <= cost_new_c;
							cost_q     <= '0;
						end else begin
							res_cost_q <= '0;
							cost_q     <= cost_new_c;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.pos        = res_pos_q;
	assign rsp.vel        = res_vel_q;
	assign rsp.acc        = res_acc_q;
	assign rsp.out_dim    = res_dim_q;
	assign rsp.step_cost  = res_cost_q;
	assign rsp.cost_valid = res_cv_q;

	// ------------------------------------------------------------ instances
	pdmd_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (mul_go_q),
		.a      (mul_a_q),
		.b      (mul_b_q),
		.stat   (mul_stat),
		.prod   (mul_prod)
	);

	pdmd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (div_go_q),
		.num    (num_q),
		.den    (mass_q),
		.stat   (div_stat),
		.quo    (div_quo)
	);

	pdmd_store #(
		.DIMS (DIMS)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (st_cmd),
		.addr   (slot_q),
		.wr_pos (np_q),
		.wr_vel (nv_q),
		.rd_pos (st_pos),
		.rd_vel (st_vel)
	);

	// ----------------------------------------------------------- assertions
	a_mul_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		mul_go_q |-> !mul_stat.busy)
		else $error("multiplier started while a product is in progress");

	a_div_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		div_go_q |-> !div_stat.busy)
		else $error("divider started while a quotient is in progress");

	a_one_unit: assert property (@(posedge clk) disable iff (!arst_n)
		!(mul_go_q && div_go_q))
		else $error("multiplier and divider started together");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result raised outside the completion state");

	a_cost_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && last_q) |=> (cost_q == '0))
		else $error("cost sum not cleared after closing a time step");

endmodule
